// ===== design/fppm_pkg.sv =====
// Package for the flow pulse period monitor.
// Holds widths, register indexes, reset values and the state and config structs.
// No dependencies.
package fppm_pkg;

  localparam int TickW   = 16;
  localparam int PeriodW = 32;
  localparam int DwellW  = 17;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegSlowThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHysteresis    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDwellTicks    = 2'd2;

  localparam logic [CfgW-1:0] SlowThresholdRst = 16'd400;
  localparam logic [CfgW-1:0] HysteresisRst    = 16'd25;
  localparam logic [CfgW-1:0] DwellTicksRst    = 16'd1000;

  typedef struct packed {
    logic [CfgW-1:0] slow_threshold;
    logic [CfgW-1:0] hysteresis;
    logic [CfgW-1:0] dwell_ticks;
  } fppm_cfg_t;

  typedef struct packed {
    logic [TickW-1:0]   tick_count;
    logic               prev_level;
    logic [TickW-1:0]   last_edge_time;
    logic [PeriodW-1:0] since_pulse;
    logic [PeriodW-1:0] period;
    logic               flow_ok;
    logic [DwellW-1:0]  dwell_count;
  } fppm_state_t;

  localparam fppm_state_t StateRst = '{
    tick_count:     '0,
    prev_level:     1'b0,
    last_edge_time: '0,
    since_pulse:    '0,
    period:         '0,
    flow_ok:        1'b1,
    dwell_count:    '0
  };

endpackage

// ===== design/fppm_cfg.sv =====
// Configuration registers of the flow pulse period monitor.
// Depends on fppm_pkg for widths, indexes and reset values.
module fppm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fppm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fppm_pkg::CfgW-1:0]    cfg_wdata,
  output fppm_pkg::fppm_cfg_t          cfg
);
  import fppm_pkg::*;

  fppm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_threshold <= SlowThresholdRst;
      cfg_r.hysteresis     <= HysteresisRst;
      cfg_r.dwell_ticks    <= DwellTicksRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSlowThreshold: cfg_r.slow_threshold <= cfg_wdata;
        RegHysteresis:    cfg_r.hysteresis     <= cfg_wdata;
        RegDwellTicks:    cfg_r.dwell_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/fppm_update.sv =====
// Next-state logic for one tick: edge detect, period, dropout stretch, dwell and flag.
// Depends on fppm_pkg for the state and config structs.
module fppm_update (
  input  fppm_pkg::fppm_state_t state,
  input  fppm_pkg::fppm_cfg_t   cfg,
  input  logic                  level,
  output fppm_pkg::fppm_state_t state_nxt
);
  import fppm_pkg::*;

  logic [TickW-1:0]   tick_inc;
  logic               rise;
  logic [PeriodW-1:0] since_inc;
  logic [PeriodW-1:0] period_new;
  logic [CfgW-1:0]    ok_level;
  logic               qualifies;
  logic [DwellW-1:0]  dwell_inc;
  logic               flip;

  always_comb begin
    tick_inc  = state.tick_count + 1'b1;
    rise      = level && !state.prev_level;
    since_inc = (&state.since_pulse) ? state.since_pulse : state.since_pulse + 1'b1;

    if (rise) begin
      period_new = {{(PeriodW-TickW){1'b0}}, tick_inc - state.last_edge_time};
    end else if (since_inc > state.period) begin
      period_new = since_inc;
    end else begin
      period_new = state.period;
    end

    ok_level = (cfg.hysteresis > cfg.slow_threshold) ? '0
             : cfg.slow_threshold - cfg.hysteresis;

    if (state.flow_ok) begin
      qualifies = period_new > {{(PeriodW-CfgW){1'b0}}, cfg.slow_threshold};
    end else begin
      qualifies = period_new < {{(PeriodW-CfgW){1'b0}}, ok_level};
    end

    dwell_inc = state.dwell_count + 1'b1;
    flip      = qualifies && (dwell_inc > {{(DwellW-CfgW){1'b0}}, cfg.dwell_ticks});

    state_nxt.tick_count     = tick_inc;
    state_nxt.prev_level     = level;
    state_nxt.last_edge_time = rise ? tick_inc : state.last_edge_time;
    state_nxt.since_pulse    = rise ? '0 : since_inc;
    state_nxt.period         = period_new;
    state_nxt.flow_ok        = flip ? !state.flow_ok : state.flow_ok;
    state_nxt.dwell_count    = (!qualifies || flip) ? '0 : dwell_inc;
  end

endmodule

// ===== design/flow_pulse_period_monitor_core.sv =====
// Top level of the flow pulse period monitor: input register, state, result register.
// Depends on fppm_pkg, fppm_cfg and fppm_update.
//
//   port group  direction  handshake           payload
//   in_         input      in_valid/in_stall   in_sensor_level
//   out_        output     out_valid/out_stall out_flow_ok, out_period_ms
//   cfg_        input      cfg_we              cfg_index, cfg_wdata
//
// One word per cycle sustained while out_stall is low; a word taken into the input register
// waits there until the update logic can advance, then its result is loaded into the
// result register and shows on out_.
// Reset (rst_n low, synchronous) empties both registers and restores state and
// registers to their defaults. While out_stall holds a result, at most one more word is
// taken into the input register; after that in_stall rises.
module flow_pulse_period_monitor_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_sensor_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_flow_ok,
  output logic [fppm_pkg::PeriodW-1:0] out_period_ms,
  input  logic                         cfg_we,
  input  logic [fppm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fppm_pkg::CfgW-1:0]    cfg_wdata
);
  import fppm_pkg::*;

  fppm_cfg_t   cfg;
  fppm_state_t state_r;
  fppm_state_t state_nxt;

  logic               in_valid_r;
  logic               in_level_r;
  logic               out_valid_r;
  logic               out_flow_ok_r;
  logic [PeriodW-1:0] out_period_r;
  logic               advance;

  fppm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fppm_update u_update (
    .state     (state_r),
    .cfg       (cfg),
    .level     (in_level_r),
    .state_nxt (state_nxt)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_level_r <= in_sensor_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateRst;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flow_ok_r <= state_nxt.flow_ok;
      out_period_r  <= state_nxt.period;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_flow_ok   = out_flow_ok_r;
  assign out_period_ms = out_period_r;

endmodule
